/* rtl/cpn_pkg.sv */
// ----------------------------------------------------------------------------
// cpn_pkg: shared constants and types
// Widths, reset values and the data records handed between the cells of the
// normalized cross product pipeline.
// ----------------------------------------------------------------------------
package cpn_pkg;

  localparam int unsigned CompW       = 16;  // Q2.14 input component
  localparam int unsigned MagW        = 32;  // |cross component|, Q4.28
  localparam int unsigned SqW         = 64;  // squared length
  localparam int unsigned RootW       = 32;  // length
  localparam int unsigned FracShift   = 14;  // Q1.14 result scale
  localparam int unsigned NumW        = MagW + FracShift;
  localparam int unsigned QuoW        = FracShift + 1;
  localparam int unsigned FrontStages = 4;
  localparam int unsigned SqrtCells   = RootW;
  localparam int unsigned DivCells    = QuoW;
  localparam int unsigned Depth       = FrontStages + SqrtCells + DivCells + 1;

  localparam logic [RootW-1:0] MinLenReset = 32'd26844;

  // record moving down the square root cells
  typedef struct packed {
    logic [SqW-1:0]            rem;
    logic [RootW-1:0]          root;
    logic [2:0]                sgn;
    logic [2:0][MagW-1:0]      mag;
  } cpn_sqrt_t;

  // record moving down the divider cells, three lanes side by side
  typedef struct packed {
    logic [RootW-1:0]          len;
    logic [2:0]                sgn;
    logic [2:0][NumW-1:0]      rem;
    logic [2:0][QuoW-1:0]      quo;
  } cpn_div_t;

endpackage

/* rtl/cross_product_normalize.sv */
// ----------------------------------------------------------------------------
// cross_product_normalize: unit right axis from tangent and normal
// Cross product, length and per-component division in one pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per vector pair: tangent x/y/z and normal x/y/z,
//   each signed Q2.14. m_axis returns the normalized cross product in Q1.14
//   on tdata and the ok flag on tuser; a degenerate item (length zero or
//   below min_length) comes out as a zero vector with ok low.
//   cfg_we_i/cfg_data_i write min_length (units 2^-28); write
//   it only while the pipeline is empty.
// Stages: 4 front stages, 32 root cells, 15 divider cells and the output
//   register lie between accept and m_axis_tvalid.
// Throughput: one item per cycle unless stalled. Each cell resolves one
//   root or quotient bit and passes its record on every enabled cycle.
// Stall: the whole chain holds while the output register is full and not
//   taken; s_axis_tready drops in the same cycle, so nothing is lost.
// Reset: valid bits clear and min_length returns to 26844.
// ----------------------------------------------------------------------------
module cross_product_normalize import cpn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RootW-1:0]   cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // tangent_x, tangent_y, tangent_z, normal_x, normal_y, normal_z
  input  logic [6*CompW-1:0] s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // right_x, right_y, right_z
  output logic [3*CompW-1:0] m_axis_tdata,
  // ok
  output logic               m_axis_tuser
);

  logic             en;
  logic [Depth-1:0] vld_q;
  logic [RootW-1:0] min_len_q;

  cpn_sqrt_t        sq_rec [SqrtCells+1];
  cpn_div_t         dv_rec [DivCells+1];

  logic             ok;
  logic [3*CompW-1:0] res_d, res_q;
  logic               ok_q;

  // chain moves whenever the output slot is free or being emptied
  assign en            = !vld_q[Depth-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      min_len_q <= MinLenReset;
    end else begin
      if (en) begin
        vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
      end
      if (cfg_we_i) begin
        min_len_q <= cfg_data_i;
      end
    end
  end

  cpn_front u_front (
    .clk_i (clk_i),
    .en_i  (en),
    .vec_i (s_axis_tdata),
    .d_o   (sq_rec[0])
  );

  // root cells, most significant bit first
  for (genvar g = 0; g < SqrtCells; g++) begin : g_sqrt
    cpn_sqrt_cell #(.K(SqrtCells - 1 - g)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (sq_rec[g]),
      .d_o   (sq_rec[g+1])
    );
  end

  // hand over: numerator is |r| scaled to Q1.14 of the result
  always_comb begin
    dv_rec[0].len = sq_rec[SqrtCells].root;
    dv_rec[0].sgn = sq_rec[SqrtCells].sgn;
    for (int i = 0; i < 3; i++) begin
      dv_rec[0].rem[i] = {sq_rec[SqrtCells].mag[i], {FracShift{1'b0}}};
      dv_rec[0].quo[i] = '0;
    end
  end

  for (genvar g = 0; g < DivCells; g++) begin : g_div
    cpn_div_cell #(.K(DivCells - 1 - g)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (dv_rec[g]),
      .d_o   (dv_rec[g+1])
    );
  end

  // zero length is degenerate even with min_length 0
  assign ok = (dv_rec[DivCells].len != '0) && (dv_rec[DivCells].len >= min_len_q);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!ok) begin
        res_d[i*CompW +: CompW] = '0;
      end else if (dv_rec[DivCells].sgn[i]) begin
        res_d[i*CompW +: CompW] = -{{(CompW-QuoW){1'b0}}, dv_rec[DivCells].quo[i]};
      end else begin
        res_d[i*CompW +: CompW] = {{(CompW-QuoW){1'b0}}, dv_rec[DivCells].quo[i]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      ok_q  <= ok;
    end
  end

  assign m_axis_tvalid = vld_q[Depth-1];
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = ok_q;

`ifndef SYNTHESIS
  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("degenerate item with nonzero vector");

  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Depth-2] && ok |-> dv_rec[DivCells].quo[0] <= QuoW'(16384) &&
                             dv_rec[DivCells].quo[1] <= QuoW'(16384) &&
                             dv_rec[DivCells].quo[2] <= QuoW'(16384))
    else $error("quotient above unit scale");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted item not in pipeline");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while stalled");
`endif

endmodule

/* rtl/cpn_front.sv */
// ----------------------------------------------------------------------------
// cpn_front: cross product and squared length
// Four register stages: products, differences, squares, sum.
// ----------------------------------------------------------------------------
module cpn_front import cpn_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [6*CompW-1:0]      vec_i,
  output cpn_sqrt_t               d_o
);

  logic signed [CompW-1:0]   tx, ty, tz, nx, ny, nz;
  logic signed [2*CompW-1:0] p_q [6];
  logic signed [2*CompW:0]   r_d [3];
  logic [2:0]                sgn2_q, sgn3_q, sgn4_q;
  logic [2:0][MagW-1:0]      mag2_q, mag3_q, mag4_q;
  logic [SqW-1:0]            sq_q [3];
  logic [SqW-1:0]            sum_q;

  assign tx = vec_i[0*CompW +: CompW];
  assign ty = vec_i[1*CompW +: CompW];
  assign tz = vec_i[2*CompW +: CompW];
  assign nx = vec_i[3*CompW +: CompW];
  assign ny = vec_i[4*CompW +: CompW];
  assign nz = vec_i[5*CompW +: CompW];

  always_comb begin
    r_d[0] = {p_q[0][2*CompW-1], p_q[0]} - {p_q[1][2*CompW-1], p_q[1]};
    r_d[1] = {p_q[2][2*CompW-1], p_q[2]} - {p_q[3][2*CompW-1], p_q[3]};
    r_d[2] = {p_q[4][2*CompW-1], p_q[4]} - {p_q[5][2*CompW-1], p_q[5]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0] <= ty * nz;
      p_q[1] <= tz * ny;
      p_q[2] <= tz * nx;
      p_q[3] <= tx * nz;
      p_q[4] <= tx * ny;
      p_q[5] <= ty * nx;
      for (int i = 0; i < 3; i++) begin
        sgn2_q[i] <= r_d[i][2*CompW];
        // |r| <= 2^31, fits the magnitude width
        mag2_q[i] <= r_d[i][2*CompW] ? MagW'(-r_d[i]) : MagW'(r_d[i]);
        sq_q[i]   <= mag2_q[i] * mag2_q[i];
      end
      sgn3_q <= sgn2_q;
      mag3_q <= mag2_q;
      sum_q  <= sq_q[0] + sq_q[1] + sq_q[2];
      sgn4_q <= sgn3_q;
      mag4_q <= mag3_q;
    end
  end

  always_comb begin
    d_o.rem  = sum_q;
    d_o.root = '0;
    d_o.sgn  = sgn4_q;
    d_o.mag  = mag4_q;
  end

endmodule

/* rtl/cpn_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// cpn_sqrt_cell: one root bit of the integer square root
// Tries root bit K against the remainder and registers the record.
// ----------------------------------------------------------------------------
module cpn_sqrt_cell import cpn_pkg::*; #(
  parameter int unsigned K = 0
) (
  input  logic      clk_i,
  input  logic      en_i,
  input  cpn_sqrt_t d_i,
  output cpn_sqrt_t d_o
);

  logic [SqW+1:0] trial;
  logic           take;
  cpn_sqrt_t      d_d, d_q;

  // (root + 2^K)^2 - root^2 = root*2^(K+1) + 2^(2K)
  assign trial = ({{(SqW+2-RootW){1'b0}}, d_i.root} << (K + 1))
               + ({{(SqW+1){1'b0}}, 1'b1} << (2 * K));
  assign take  = {2'b00, d_i.rem} >= trial;

  always_comb begin
    d_d = d_i;
    if (take) begin
      d_d.rem     = d_i.rem - trial[SqW-1:0];
      d_d.root[K] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

/* rtl/cpn_div_cell.sv */
// ----------------------------------------------------------------------------
// cpn_div_cell: one quotient bit, three lanes
// Restoring division step of |r| * 2^14 by the length.
// ----------------------------------------------------------------------------
module cpn_div_cell import cpn_pkg::*; #(
  parameter int unsigned K = 0
) (
  input  logic     clk_i,
  input  logic     en_i,
  input  cpn_div_t d_i,
  output cpn_div_t d_o
);

  logic [NumW:0] lsh;
  logic [2:0]    take;
  cpn_div_t      d_d, d_q;

  assign lsh = {{(NumW+1-RootW){1'b0}}, d_i.len} << K;

  always_comb begin
    d_d = d_i;
    for (int i = 0; i < 3; i++) begin
      take[i] = {1'b0, d_i.rem[i]} >= lsh;
      if (take[i]) begin
        d_d.rem[i]    = d_i.rem[i] - lsh[NumW-1:0];
        d_d.quo[i][K] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule
